### design/prrfq_pkg.sv
// Shared types, constants and helpers of the four-queue priority arbiter.
package prrfq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int NUM_QUEUES  = 4;
	localparam int RAM_DEPTH   = NUM_QUEUES * QUEUE_DEPTH;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W      = $clog2(RAM_DEPTH);
	localparam int IDENT_W     = 32;

	typedef logic [1:0]         queue_t;
	typedef logic [PTR_W-1:0]   ptr_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [IDENT_W-1:0] ident_t;

	localparam queue_t Q_WEST  = 2'd0;
	localparam queue_t Q_NORTH = 2'd1;
	localparam queue_t Q_SOUTH = 2'd2;
	localparam queue_t Q_EAST  = 2'd3;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_PUSHED  = 2'd0,
		ST_POPPED  = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_DROPPED = 2'd3
	} status_t;

	typedef struct packed {
		logic   req_type;
		queue_t direction;
		ident_t ident_in;
	} req_t;

	typedef struct packed {
		status_t status;
		ident_t  ident_out;
		logic    all_empty;
	} rsp_t;

	// Memory access issued for one request.
	typedef struct packed {
		logic  wr_en;
		logic  rd_en;
		addr_t addr;
	} mem_op_t;

	// Outcome of one request, known at accept time.
	typedef struct packed {
		status_t status;
		logic    all_empty;
	} verdict_t;

	// Round-robin successor among north, south and east.
	function automatic queue_t rot_step(input queue_t q);
		return (q == Q_EAST) ? Q_NORTH : queue_t'(q + 2'd1);
	endfunction

	function automatic ptr_t ptr_inc(input ptr_t p);
		return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
	endfunction

endpackage

### design/prrfq_if.sv
// Request and response channel interfaces of the four-queue arbiter.
interface prrfq_req_if;
	logic               valid;
	logic               ready;
	prrfq_pkg::req_t    payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface prrfq_rsp_if;
	logic               valid;
	logic               ready;
	prrfq_pkg::rsp_t    payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### design/prrfq_ram.sv
// Single-port identifier store with registered read data.
module prrfq_ram (
	input  logic              clk,
	input  prrfq_pkg::mem_op_t op,
	input  prrfq_pkg::ident_t  wdata,
	output prrfq_pkg::ident_t  rdata
);

	prrfq_pkg::ident_t mem [prrfq_pkg::RAM_DEPTH];

	always_ff @(posedge clk) begin
		if (op.wr_en) begin
			mem[op.addr] <= wdata;
		end
		if (op.rd_en) begin
			rdata <= mem[op.addr];
		end
	end

endmodule

### design/prrfq_ctrl.sv
// Queue pointers, fill counts and west-first round-robin selection.
module prrfq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  prrfq_pkg::req_t     req,
	output prrfq_pkg::mem_op_t  op,
	output prrfq_pkg::verdict_t verdict
);

	prrfq_pkg::ptr_t   rp_q   [prrfq_pkg::NUM_QUEUES];
	prrfq_pkg::ptr_t   wp_q   [prrfq_pkg::NUM_QUEUES];
	prrfq_pkg::cnt_t   fill_q [prrfq_pkg::NUM_QUEUES];
	prrfq_pkg::cnt_t   fill_nxt [prrfq_pkg::NUM_QUEUES];
	prrfq_pkg::queue_t rot_q;

	logic [prrfq_pkg::NUM_QUEUES-1:0] nonempty;
	logic              is_pop;
	logic              full;
	logic              push_ok;
	logic              pop_ok;
	logic              rest_empty;
	prrfq_pkg::queue_t cand0, cand1, cand2, rr_q, serve_q, tgt_q;
	prrfq_pkg::ptr_t   ptr;

	always_comb begin
		for (int i = 0; i < prrfq_pkg::NUM_QUEUES; i++) begin
			nonempty[i] = (fill_q[i] != '0);
		end
	end

	// Walk the rotation from its pointer, skipping empty queues.
	assign cand0 = rot_q;
	assign cand1 = prrfq_pkg::rot_step(cand0);
	assign cand2 = prrfq_pkg::rot_step(cand1);
	assign rr_q  = nonempty[cand0] ? cand0 : (nonempty[cand1] ? cand1 : cand2);

	assign serve_q = nonempty[prrfq_pkg::Q_WEST] ? prrfq_pkg::Q_WEST : rr_q;
	assign is_pop  = (req.req_type == prrfq_pkg::REQ_POP);
	assign tgt_q   = is_pop ? serve_q : req.direction;
	assign full    = (fill_q[tgt_q] == prrfq_pkg::cnt_t'(prrfq_pkg::QUEUE_DEPTH));
	assign push_ok = !is_pop && !full;
	assign pop_ok  = is_pop && (|nonempty);
	assign ptr     = is_pop ? rp_q[tgt_q] : wp_q[tgt_q];

	always_comb begin
		for (int i = 0; i < prrfq_pkg::NUM_QUEUES; i++) begin
			if (prrfq_pkg::queue_t'(i) == tgt_q && push_ok) begin
				fill_nxt[i] = prrfq_pkg::cnt_t'(fill_q[i] + 1'b1);
			end else if (prrfq_pkg::queue_t'(i) == tgt_q && pop_ok) begin
				fill_nxt[i] = prrfq_pkg::cnt_t'(fill_q[i] - 1'b1);
			end else begin
				fill_nxt[i] = fill_q[i];
			end
		end
	end

	assign rest_empty = (fill_nxt[prrfq_pkg::Q_NORTH] == '0)
		&& (fill_nxt[prrfq_pkg::Q_SOUTH] == '0)
		&& (fill_nxt[prrfq_pkg::Q_EAST] == '0);

	always_comb begin
		op.wr_en = take && push_ok;
		op.rd_en = take && pop_ok;
		op.addr  = prrfq_pkg::addr_t'(tgt_q) * prrfq_pkg::addr_t'(prrfq_pkg::QUEUE_DEPTH)
			+ prrfq_pkg::addr_t'(ptr);
	end

	always_comb begin
		if (is_pop) begin
			verdict.status = pop_ok ? prrfq_pkg::ST_POPPED : prrfq_pkg::ST_EMPTY;
		end else begin
			verdict.status = full ? prrfq_pkg::ST_DROPPED : prrfq_pkg::ST_PUSHED;
		end
		verdict.all_empty = rest_empty && (fill_nxt[prrfq_pkg::Q_WEST] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < prrfq_pkg::NUM_QUEUES; i++) begin
				rp_q[i]   <= '0;
				wp_q[i]   <= '0;
				fill_q[i] <= '0;
			end
			rot_q <= prrfq_pkg::Q_NORTH;
		end else if (take) begin
			for (int i = 0; i < prrfq_pkg::NUM_QUEUES; i++) begin
				fill_q[i] <= fill_nxt[i];
			end
			if (push_ok) begin
				wp_q[tgt_q] <= prrfq_pkg::ptr_inc(ptr);
			end
			if (pop_ok) begin
				rp_q[tgt_q] <= prrfq_pkg::ptr_inc(ptr);
				// West pops leave the rotation alone.
				if (!nonempty[prrfq_pkg::Q_WEST]) begin
					rot_q <= rest_empty ? prrfq_pkg::Q_NORTH : prrfq_pkg::rot_step(serve_q);
				end
			end
		end
	end

endmodule

### design/priority_round_robin_four_queues_unit.sv
// Top level of the four-queue arbiter: west by strict priority, others round robin.
// Path: an accepted request reads the store in the request stage, then loads the
// response register. Throughput: one request per cycle, set by the
// single read-or-write port of the identifier store; a stalled response holds input.
// Reset (arst_n low, asynchronous): pointers and fill counts clear, rotation points
// at north, no response pending. Store contents stay undefined until pushed.
module priority_round_robin_four_queues_unit (
	input  logic       clk,
	input  logic       arst_n,
	prrfq_req_if.sink  req,
	prrfq_rsp_if.source rsp
);

	logic                take;
	logic                adv;
	prrfq_pkg::mem_op_t  op;
	prrfq_pkg::verdict_t verdict;
	prrfq_pkg::ident_t   rdata;

	// Request stage: the store read is in flight here.
	logic                pend_s1;
	prrfq_pkg::verdict_t verdict_s1;

	// Response register.
	logic                rsp_valid_q;
	prrfq_pkg::rsp_t     rsp_q;

	// Advance the request stage when the response register is free or draining.
	assign adv       = !rsp_valid_q || rsp.ready;
	assign req.ready = !pend_s1 || adv;
	assign take      = req.valid && req.ready;

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// Decide push, pop and the served queue from the pointer state.
	prrfq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.req     (req.payload),
		.op      (op),
		.verdict (verdict)
	);

	// Identifier store: a push writes, a pop reads, never both.
	prrfq_ram u_ram (
		.clk   (clk),
		.op    (op),
		.wdata (req.payload.ident_in),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (take) begin
			pend_s1 <= 1'b1;
		end else if (adv) begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			verdict_s1 <= verdict;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (pend_s1 && adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Load the response; only a served pop carries the stored identifier.
	always_ff @(posedge clk) begin
		if (pend_s1 && adv) begin
			rsp_q.status    <= verdict_s1.status;
			rsp_q.all_empty <= verdict_s1.all_empty;
			rsp_q.ident_out <= (verdict_s1.status == prrfq_pkg::ST_POPPED) ? rdata : '0;
		end
	end

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(op.wr_en && op.rd_en))
		else $error("store written and read in the same cycle");

	a_take_pends: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> pend_s1)
		else $error("accepted request not held in request stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 && !adv |=> pend_s1 && $stable(verdict_s1))
		else $error("pending request lost during response stall");

	a_zero_ident: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status != prrfq_pkg::ST_POPPED |-> rsp_q.ident_out == '0)
		else $error("non-pop response carries an identifier");

endmodule
